FILE: rtl/tpc_pkg.sv
// Shared constants and types for the timer period to prescale and count core.
package tpc_pkg;

    localparam int NUM_TIMERS     = 4;
    localparam int MAX_PRESCALE   = 7;
    localparam int COUNT_BITS     = 32;
    localparam int WDG_COUNT_BITS = 16;

    localparam int CLK_W    = 8;
    localparam int IDX_W    = 2;
    localparam int PER_W    = 32;
    localparam int PRE_W    = 3;
    localparam int STAT_W   = 2;
    localparam int RATE_W   = 15;
    localparam int PROD_W   = PER_W + RATE_W;
    localparam int LIM_W    = PER_W + 10;
    localparam int STEP_W   = 6;
    localparam int CNT_W    = 32;

    localparam logic [CNT_W-1:0] CMAX_ORD = CNT_W'((64'd1 << COUNT_BITS) - 64'd1);
    localparam logic [CNT_W-1:0] CMAX_WDG = CNT_W'((64'd1 << WDG_COUNT_BITS) - 64'd1);

    localparam logic [RATE_W-1:0] WDG_TICK_DIV = RATE_W'(14);
    localparam logic [RATE_W-1:0] MS_PER_S     = RATE_W'(1000);

    localparam logic [STEP_W-1:0] MUL_STEPS     = STEP_W'(RATE_W);
    localparam logic [STEP_W-1:0] DIV_W_STEPS   = STEP_W'(18);
    localparam logic [STEP_W-1:0] DIV_LIM_STEPS = STEP_W'(32);
    localparam logic [STEP_W-1:0] DIV_CNT_STEPS = STEP_W'(PROD_W);

    localparam logic REG_CLOCK_RATE = 1'b0;
    localparam logic REG_WATCHDOG   = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_RANGE   = 2'd2
    } status_t;

endpackage

FILE: rtl/timer_period_to_prescale_and_count_core.sv
// Timer period to prescale exponent and load count, with a bit-serial datapath.
// An invalid request goes straight to the result. An ordinary timer runs a 32-step limit
// division, 1 to 8 prescale search steps and a 15-step multiply; the watchdog adds a clock
// multiply, a limit multiply and two more divisions.
// One request is in flight at a time; a new one is taken once the sequencer is idle, even
// while the previous result still waits in the output register. rst_n is asynchronous.
// Reset clears the sequencer, the output valid flag and loads clock_rate 12, watchdog 2.
module timer_period_to_prescale_and_count_core
    import tpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [1:0] timer_index, [33:2] period_us, [39:34] zero
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [1:0] status, [4:2] prescale, [36:5] load_count,
                                   // [39:37] zero
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL_W,
        S_DIV_W,
        S_DIV_LIM,
        S_MUL_LIM,
        S_SRCH,
        S_MUL_CNT,
        S_DIV_CNT,
        S_DONE
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [CLK_W-1:0] clock_rate_reg;
    logic [IDX_W-1:0] watchdog_reg;

    // Captured request and per-request control.
    logic [IDX_W-1:0] idx_reg;
    logic [PER_W-1:0] per_reg;
    logic             wdg_reg;
    logic             small_reg;
    logic [PRE_W-1:0] pre_reg;
    status_t          stat_reg;

    // Rate (clock or watchdog ticks), count limit and the shifted operands used by the
    // prescale search. During the search psh_reg holds period / divider and wsh_reg rate / divider.
    logic [RATE_W-1:0] rate_reg;
    logic [LIM_W-1:0]  lim_reg;
    logic [PER_W-2:0]  psh_reg;
    logic [RATE_W-2:0] wsh_reg;

    // Shared shift-add multiplier and restoring divider, one bit per cycle.
    logic [STEP_W-1:0] step_reg;
    logic [PROD_W-1:0] ma_reg;
    logic [RATE_W-1:0] mb_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [PROD_W-1:0] dvd_reg;
    logic [RATE_W-1:0] rem_reg;
    logic [RATE_W-1:0] dsr_reg;

    // Output register.
    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;

    logic [PROD_W-1:0] acc_next;
    logic [RATE_W:0]   trial;
    logic              trial_ge;
    logic [RATE_W-1:0] rem_next;
    logic [PROD_W-1:0] dvd_next;
    logic              last_step;
    logic              in_xfer;
    logic              cfg_wr;
    logic              out_free;
    logic              req_bad;
    logic              is_wdg;
    logic              over_lim;
    logic [3:0]        shamt;
    logic [PROD_W-1:0] raw_cnt;
    logic [PROD_W-1:0] cmax_ext;
    logic [CNT_W-1:0]  final_cnt;

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        case (paddr[2])
            REG_CLOCK_RATE: prdata = {24'd0, clock_rate_reg};
            REG_WATCHDOG:   prdata = {30'd0, watchdog_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // One multiplier step: add the shifted multiplicand when the low multiplier bit is set.
    assign acc_next = mb_reg[0] ? acc_reg + ma_reg : acc_reg;

    // One divider step: bring down the next dividend bit and try a subtraction.
    assign trial    = {rem_reg, dvd_reg[PROD_W-1]};
    assign trial_ge = (trial >= {1'b0, dsr_reg});
    assign rem_next = trial_ge ? RATE_W'(trial - {1'b0, dsr_reg}) : trial[RATE_W-1:0];
    assign dvd_next = {dvd_reg[PROD_W-2:0], trial_ge};

    assign last_step = (step_reg == STEP_W'(1));

    assign req_bad  = ({{(32-IDX_W){1'b0}}, idx_reg} >= 32'(NUM_TIMERS))
                      || (per_reg == '0) || (clock_rate_reg == '0);
    assign is_wdg   = (idx_reg == watchdog_reg);
    assign over_lim = ({{(LIM_W-PER_W+1){1'b0}}, psh_reg} > lim_reg);

    // Final count: ordinary timers with a period below the divider scale the product down
    // by the divider; the watchdog count comes out of the divide-by-1000 pass.
    assign shamt    = {1'b0, pre_reg} + 4'd1;
    assign raw_cnt  = wdg_reg ? dvd_reg : (small_reg ? (acc_reg >> shamt) : acc_reg);
    assign cmax_ext = {{(PROD_W-CNT_W){1'b0}}, (wdg_reg ? CMAX_WDG : CMAX_ORD)};
    assign final_cnt = (raw_cnt > cmax_ext) ? cmax_ext[CNT_W-1:0] : raw_cnt[CNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            clock_rate_reg <= CLK_W'(12);
            watchdog_reg   <= IDX_W'(2);
            m_tvalid_reg   <= 1'b0;
            step_reg       <= '0;
            stat_reg       <= STAT_OK;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (paddr[2])
                    REG_CLOCK_RATE: clock_rate_reg <= pwdata[CLK_W-1:0];
                    REG_WATCHDOG:   watchdog_reg   <= pwdata[IDX_W-1:0];
                    default:        ;
                endcase
            end

            // In the done state the output register is reloaded below instead.
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        idx_reg   <= s_tdata[1:0];
                        per_reg   <= s_tdata[33:2];
                        state_reg <= S_CHECK;
                    end
                end

                S_CHECK:
                begin
                    wdg_reg <= is_wdg;
                    rem_reg <= '0;
                    acc_reg <= '0;
                    if (req_bad)
                    begin
                        stat_reg  <= STAT_INVALID;
                        state_reg <= S_DONE;
                    end
                    else if (is_wdg)
                    begin
                        // Watchdog tick rate starts with clock * 1000.
                        ma_reg    <= {{(PROD_W-CLK_W){1'b0}}, clock_rate_reg};
                        mb_reg    <= MS_PER_S;
                        step_reg  <= MUL_STEPS;
                        state_reg <= S_MUL_W;
                    end
                    else
                    begin
                        rate_reg  <= {{(RATE_W-CLK_W){1'b0}}, clock_rate_reg};
                        dvd_reg   <= {CMAX_ORD, {(PROD_W-CNT_W){1'b0}}};
                        dsr_reg   <= {{(RATE_W-CLK_W){1'b0}}, clock_rate_reg};
                        step_reg  <= DIV_LIM_STEPS;
                        state_reg <= S_DIV_LIM;
                    end
                end

                S_MUL_W, S_MUL_LIM, S_MUL_CNT:
                begin
                    acc_reg  <= acc_next;
                    ma_reg   <= {ma_reg[PROD_W-2:0], 1'b0};
                    mb_reg   <= {1'b0, mb_reg[RATE_W-1:1]};
                    if (!last_step)
                    begin
                        step_reg <= step_reg - STEP_W'(1);
                    end
                    else
                    begin
                        rem_reg <= '0;
                        case (state_reg)
                            S_MUL_W:
                            begin
                                dvd_reg   <= {acc_next[17:0], {(PROD_W-18){1'b0}}};
                                dsr_reg   <= WDG_TICK_DIV;
                                step_reg  <= DIV_W_STEPS;
                                state_reg <= S_DIV_W;
                            end
                            S_MUL_LIM:
                            begin
                                lim_reg   <= acc_next[LIM_W-1:0];
                                psh_reg   <= per_reg[PER_W-1:1];
                                wsh_reg   <= rate_reg[RATE_W-1:1];
                                pre_reg   <= '0;
                                state_reg <= S_SRCH;
                            end
                            default:
                            begin
                                if (wdg_reg)
                                begin
                                    dvd_reg   <= acc_next;
                                    dsr_reg   <= MS_PER_S;
                                    step_reg  <= DIV_CNT_STEPS;
                                    state_reg <= S_DIV_CNT;
                                end
                                else
                                begin
                                    stat_reg  <= STAT_OK;
                                    state_reg <= S_DONE;
                                end
                            end
                        endcase
                    end
                end

                S_DIV_W, S_DIV_LIM, S_DIV_CNT:
                begin
                    if (!last_step)
                    begin
                        dvd_reg  <= dvd_next;
                        rem_reg  <= rem_next;
                        step_reg <= step_reg - STEP_W'(1);
                    end
                    else
                    begin
                        rem_reg <= '0;
                        case (state_reg)
                            S_DIV_W:
                            begin
                                // Watchdog ticks per millisecond, then limit = cmax / rate.
                                rate_reg  <= dvd_next[RATE_W-1:0];
                                dsr_reg   <= dvd_next[RATE_W-1:0];
                                dvd_reg   <= {CMAX_WDG, {(PROD_W-CNT_W){1'b0}}};
                                step_reg  <= DIV_LIM_STEPS;
                                state_reg <= S_DIV_LIM;
                            end
                            S_DIV_LIM:
                            begin
                                if (wdg_reg)
                                begin
                                    ma_reg    <= {{(PROD_W-32){1'b0}}, dvd_next[31:0]};
                                    mb_reg    <= MS_PER_S;
                                    acc_reg   <= '0;
                                    step_reg  <= MUL_STEPS;
                                    state_reg <= S_MUL_LIM;
                                end
                                else
                                begin
                                    lim_reg   <= {{(LIM_W-32){1'b0}}, dvd_next[31:0]};
                                    psh_reg   <= per_reg[PER_W-1:1];
                                    wsh_reg   <= rate_reg[RATE_W-1:1];
                                    pre_reg   <= '0;
                                    state_reg <= S_SRCH;
                                end
                            end
                            default:
                            begin
                                dvd_reg   <= dvd_next;
                                stat_reg  <= STAT_OK;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end

                S_SRCH:
                begin
                    if (over_lim)
                    begin
                        if (pre_reg == PRE_W'(MAX_PRESCALE))
                        begin
                            stat_reg  <= STAT_RANGE;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            pre_reg <= pre_reg + PRE_W'(1);
                            psh_reg <= {1'b0, psh_reg[PER_W-2:1]};
                            wsh_reg <= {1'b0, wsh_reg[RATE_W-2:1]};
                        end
                    end
                    else
                    begin
                        // Prescale found; form the count product.
                        small_reg <= (psh_reg == '0);
                        ma_reg    <= (psh_reg == '0)
                                     ? {{(PROD_W-PER_W){1'b0}}, per_reg}
                                     : {{(PROD_W-PER_W+1){1'b0}}, psh_reg};
                        mb_reg    <= (wdg_reg && (psh_reg == '0))
                                     ? {1'b0, wsh_reg} : rate_reg;
                        acc_reg   <= '0;
                        step_reg  <= MUL_STEPS;
                        state_reg <= S_MUL_CNT;
                    end
                end

                S_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        if (stat_reg == STAT_OK)
                        begin
                            m_tdata_reg <= {3'd0, final_cnt, pre_reg, stat_reg};
                        end
                        else
                        begin
                            m_tdata_reg <= {3'd0, {CNT_W{1'b0}}, {PRE_W{1'b0}}, stat_reg};
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // A failed request carries no prescale and no count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] != STAT_OK)) |-> (m_tdata[36:2] == '0))
        else $error("failed result carries nonzero prescale or count");

    // The sequencer is busy in the cycle after a request transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while sequencer busy");

    // The prescale search never runs past the largest exponent.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH) |-> (pre_reg <= PRE_W'(MAX_PRESCALE)))
        else $error("prescale search out of range");

    // The serial units always have a step left while running.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MUL_W) || (state_reg == S_MUL_LIM) || (state_reg == S_MUL_CNT)
         || (state_reg == S_DIV_W) || (state_reg == S_DIV_LIM)
         || (state_reg == S_DIV_CNT)) |-> (step_reg != '0))
        else $error("serial step counter underflow");

endmodule
